[sv/sxmt_pkg.sv]
// ----------------------------------------------------------------------------
// sxmt_pkg
// Shared constants, types and link helpers for the subarray XOR trie.
// ----------------------------------------------------------------------------
`default_nettype none

package sxmt_pkg;

  localparam int VALUE_BITS = 32;
  localparam int NODE_COUNT = 32768;
  localparam int NODE_W     = $clog2(NODE_COUNT);
  localparam int ENTRY_W    = 2 * NODE_W;
  localparam int USED_W     = NODE_W + 1;
  localparam int LVL_W      = $clog2(VALUE_BITS);

  localparam logic [USED_W:0] NODE_LIMIT = (USED_W + 1)'(NODE_COUNT);

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_WALK = 6'b000010,
    S_UPD  = 6'b000100,
    S_INS  = 6'b001000,
    S_LEAF = 6'b010000,
    S_FIN  = 6'b100000
  } state_t;

  typedef struct packed {
    logic [NODE_W-1:0] next_node;
    logic              bit_v;
    logic              dead;
  } step_res_t;

  function automatic logic [NODE_W-1:0] link_get(input logic [ENTRY_W-1:0] entry,
                                                 input logic sel);
    link_get = sel ? entry[ENTRY_W-1:NODE_W] : entry[NODE_W-1:0];
  endfunction

  function automatic logic [ENTRY_W-1:0] link_set(input logic [ENTRY_W-1:0] entry,
                                                  input logic sel,
                                                  input logic [NODE_W-1:0] link);
    logic [ENTRY_W-1:0] e;
    e = entry;
    if (sel) begin
      e[ENTRY_W-1:NODE_W] = link;
    end else begin
      e[NODE_W-1:0] = link;
    end
    link_set = e;
  endfunction

endpackage

`default_nettype wire

[sv/subarray_xor_max_min_trie.sv]
// ----------------------------------------------------------------------------
// subarray_xor_max_min_trie
// Running maximum and minimum XOR over contiguous runs, kept with a binary
// trie of prefix XORs walked one level per cycle.
// ----------------------------------------------------------------------------
// Each item walks all 32 levels, then updates the best values; a new prefix
// also inserts its path of up to 32 nodes (one link write per new node, one
// leaf clear) before a finish step; the node memory has one write port.
// Input is taken only in idle, so a new item waits until the last result is out.
// Reset clears the control state, the root links and the best values; the
// node memory needs no clearing pass since every node is written on allocation.
// ----------------------------------------------------------------------------
`default_nettype none

module subarray_xor_max_min_trie (
  input  wire                            clk,
  input  wire                            rst_n,
  input  wire                            in_valid,
  output logic                           in_stall,
  input  wire  [sxmt_pkg::VALUE_BITS-1:0] in_value,
  input  wire                            in_first_of_set,
  output logic                           out_valid,
  input  wire                            out_stall,
  output logic [sxmt_pkg::VALUE_BITS-1:0] out_max_xor,
  output logic [sxmt_pkg::VALUE_BITS-1:0] out_min_xor,
  output logic                           out_pool_full
);
  import sxmt_pkg::*;

  state_t                state_r, state_nxt;
  logic [LVL_W-1:0]      lvl_r, lvl_nxt;
  logic [VALUE_BITS-1:0] pfx_r, pfx_nxt;
  logic [VALUE_BITS-1:0] acc_hi_r, acc_hi_nxt;
  logic [VALUE_BITS-1:0] acc_lo_r, acc_lo_nxt;
  logic                  dead_hi_r, dead_hi_nxt;
  logic                  dead_lo_r, dead_lo_nxt;
  logic [NODE_W-1:0]     node_lo_r, node_lo_nxt;
  logic                  matching_r, matching_nxt;
  logic                  miss_r, miss_nxt;
  logic [LVL_W-1:0]      ins_lvl_r, ins_lvl_nxt;
  logic [NODE_W-1:0]     ins_node_r, ins_node_nxt;
  logic [ENTRY_W-1:0]    ins_ent_r, ins_ent_nxt;
  logic                  empty_r, empty_nxt;
  logic [ENTRY_W-1:0]    root_r, root_nxt;
  logic [USED_W-1:0]     used_r, used_nxt;
  logic [VALUE_BITS-1:0] best_max_r, best_max_nxt;
  logic [VALUE_BITS-1:0] best_min_r, best_min_nxt;
  logic                  ovf_r, ovf_nxt;
  logic [NODE_W-1:0]     wnode_r, wnode_nxt;
  logic [ENTRY_W-1:0]    went_r, went_nxt;
  logic [LVL_W-1:0]      wlvl_r, wlvl_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic [VALUE_BITS-1:0] out_max_r, out_max_nxt;
  logic [VALUE_BITS-1:0] out_min_r, out_min_nxt;
  logic                  out_full_r, out_full_nxt;

  logic                  in_xfer;
  logic [ENTRY_W-1:0]    ent_hi, ent_lo, rd_hi, rd_lo;
  step_res_t             res_hi, res_lo;
  logic                  mem_we;
  logic [ENTRY_W-1:0]    mem_wdata;
  logic [ENTRY_W-1:0]    link_ent;
  logic [VALUE_BITS-1:0] cand_hi, cand_lo;
  logic [LVL_W:0]        needed;
  logic [USED_W:0]       used_sum;

  assign in_stall      = (state_r != S_IDLE);
  assign in_xfer       = in_valid && !in_stall;
  assign out_valid     = out_valid_r;
  assign out_max_xor   = out_max_r;
  assign out_min_xor   = out_min_r;
  assign out_pool_full = out_full_r;

  assign ent_hi = (lvl_r == LVL_W'(VALUE_BITS - 1)) ? root_r : rd_hi;
  assign ent_lo = (lvl_r == LVL_W'(VALUE_BITS - 1)) ? root_r : rd_lo;

  sxmt_step u_step_hi (
    .entry    (ent_hi),
    .key_bit  (pfx_r[lvl_r]),
    .want_opp (1'b1),
    .dead_in  (dead_hi_r),
    .res      (res_hi)
  );

  sxmt_step u_step_lo (
    .entry    (ent_lo),
    .key_bit  (pfx_r[lvl_r]),
    .want_opp (1'b0),
    .dead_in  (dead_lo_r),
    .res      (res_lo)
  );

  assign link_ent  = link_set(went_r, pfx_r[wlvl_r], used_r[NODE_W-1:0]);
  assign mem_we    = ((state_r == S_INS) && (wnode_r != '0)) || (state_r == S_LEAF);
  assign mem_wdata = (state_r == S_LEAF) ? '0 : link_ent;

  sxmt_mem u_mem (
    .clk     (clk),
    .we      (mem_we),
    .waddr   (wnode_r),
    .wdata   (mem_wdata),
    .raddr_a (res_hi.next_node),
    .raddr_b (res_lo.next_node),
    .rdata_a (rd_hi),
    .rdata_b (rd_lo)
  );

  always_comb begin
    cand_hi  = (empty_r || (acc_hi_r < pfx_r)) ? pfx_r : acc_hi_r;
    cand_lo  = (empty_r || (acc_lo_r > pfx_r)) ? pfx_r : acc_lo_r;
    needed   = {1'b0, ins_lvl_r} + (LVL_W + 1)'(1);
    used_sum = {1'b0, used_r} + (USED_W + 1)'(needed);
  end

  always_comb begin
    state_nxt     = state_r;
    lvl_nxt       = lvl_r;
    pfx_nxt       = pfx_r;
    acc_hi_nxt    = acc_hi_r;
    acc_lo_nxt    = acc_lo_r;
    dead_hi_nxt   = dead_hi_r;
    dead_lo_nxt   = dead_lo_r;
    node_lo_nxt   = node_lo_r;
    matching_nxt  = matching_r;
    miss_nxt      = miss_r;
    ins_lvl_nxt   = ins_lvl_r;
    ins_node_nxt  = ins_node_r;
    ins_ent_nxt   = ins_ent_r;
    empty_nxt     = empty_r;
    root_nxt      = root_r;
    used_nxt      = used_r;
    best_max_nxt  = best_max_r;
    best_min_nxt  = best_min_r;
    ovf_nxt       = ovf_r;
    wnode_nxt     = wnode_r;
    went_nxt      = went_r;
    wlvl_nxt      = wlvl_r;
    out_max_nxt   = out_max_r;
    out_min_nxt   = out_min_r;
    out_full_nxt  = out_full_r;
    out_valid_nxt = out_valid_r && out_stall;

    unique case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          lvl_nxt      = LVL_W'(VALUE_BITS - 1);
          acc_hi_nxt   = '0;
          acc_lo_nxt   = '0;
          dead_hi_nxt  = 1'b0;
          dead_lo_nxt  = 1'b0;
          node_lo_nxt  = '0;
          matching_nxt = 1'b1;
          miss_nxt     = 1'b0;
          if (in_first_of_set) begin
            pfx_nxt      = in_value;
            root_nxt     = '0;
            used_nxt     = USED_W'(1);
            best_max_nxt = '0;
            best_min_nxt = '1;
            ovf_nxt      = 1'b0;
            empty_nxt    = 1'b1;
          end else begin
            pfx_nxt   = pfx_r ^ in_value;
            empty_nxt = (root_r == '0);
          end
          state_nxt = S_WALK;
        end
      end
      S_WALK: begin
        acc_hi_nxt  = {acc_hi_r[VALUE_BITS-2:0], res_hi.bit_v};
        acc_lo_nxt  = {acc_lo_r[VALUE_BITS-2:0], res_lo.bit_v};
        dead_hi_nxt = res_hi.dead;
        dead_lo_nxt = res_lo.dead;
        node_lo_nxt = res_lo.next_node;
        if (matching_r && (link_get(ent_lo, pfx_r[lvl_r]) == '0)) begin
          matching_nxt = 1'b0;
          miss_nxt     = 1'b1;
          ins_lvl_nxt  = lvl_r;
          ins_node_nxt = node_lo_r;
          ins_ent_nxt  = ent_lo;
        end
        if (lvl_r == '0) begin
          state_nxt = S_UPD;
        end else begin
          lvl_nxt = lvl_r - LVL_W'(1);
        end
      end
      S_UPD: begin
        if (cand_hi > best_max_r) begin
          best_max_nxt = cand_hi;
        end
        if (cand_lo < best_min_r) begin
          best_min_nxt = cand_lo;
        end
        if (!miss_r) begin
          state_nxt = S_FIN;
        end else if (used_sum > NODE_LIMIT) begin
          ovf_nxt   = 1'b1;
          state_nxt = S_FIN;
        end else begin
          wnode_nxt = ins_node_r;
          went_nxt  = ins_ent_r;
          wlvl_nxt  = ins_lvl_r;
          state_nxt = S_INS;
        end
      end
      S_INS: begin
        if (wnode_r == '0) begin
          root_nxt = link_ent;
        end
        used_nxt  = used_r + USED_W'(1);
        wnode_nxt = used_r[NODE_W-1:0];
        went_nxt  = '0;
        if (wlvl_r == '0) begin
          state_nxt = S_LEAF;
        end else begin
          wlvl_nxt = wlvl_r - LVL_W'(1);
        end
      end
      S_LEAF: begin
        state_nxt = S_FIN;
      end
      S_FIN: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_max_nxt   = best_max_r;
          out_min_nxt   = best_min_r;
          out_full_nxt  = ovf_r;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      pfx_r       <= '0;
      root_r      <= '0;
      used_r      <= USED_W'(1);
      best_max_r  <= '0;
      best_min_r  <= '1;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pfx_r       <= pfx_nxt;
      root_r      <= root_nxt;
      used_r      <= used_nxt;
      best_max_r  <= best_max_nxt;
      best_min_r  <= best_min_nxt;
      ovf_r       <= ovf_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    lvl_r      <= lvl_nxt;
    acc_hi_r   <= acc_hi_nxt;
    acc_lo_r   <= acc_lo_nxt;
    dead_hi_r  <= dead_hi_nxt;
    dead_lo_r  <= dead_lo_nxt;
    node_lo_r  <= node_lo_nxt;
    matching_r <= matching_nxt;
    miss_r     <= miss_nxt;
    ins_lvl_r  <= ins_lvl_nxt;
    ins_node_r <= ins_node_nxt;
    ins_ent_r  <= ins_ent_nxt;
    empty_r    <= empty_nxt;
    wnode_r    <= wnode_nxt;
    went_r     <= went_nxt;
    wlvl_r     <= wlvl_nxt;
    out_max_r  <= out_max_nxt;
    out_min_r  <= out_min_nxt;
    out_full_r <= out_full_nxt;
  end

endmodule

`default_nettype wire

[sv/sxmt_mem.sv]
// ----------------------------------------------------------------------------
// sxmt_mem
// Trie node store: one write port and two registered read ports.
// ----------------------------------------------------------------------------
`default_nettype none

module sxmt_mem (
  input  wire                         clk,
  input  wire                         we,
  input  wire  [sxmt_pkg::NODE_W-1:0]  waddr,
  input  wire  [sxmt_pkg::ENTRY_W-1:0] wdata,
  input  wire  [sxmt_pkg::NODE_W-1:0]  raddr_a,
  input  wire  [sxmt_pkg::NODE_W-1:0]  raddr_b,
  output logic [sxmt_pkg::ENTRY_W-1:0] rdata_a,
  output logic [sxmt_pkg::ENTRY_W-1:0] rdata_b
);
  import sxmt_pkg::*;

  logic [ENTRY_W-1:0] mem [NODE_COUNT];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

`default_nettype wire

[sv/sxmt_step.sv]
// ----------------------------------------------------------------------------
// sxmt_step
// One greedy level of a trie walk: picks the preferred child or falls back.
// ----------------------------------------------------------------------------
`default_nettype none

module sxmt_step (
  input  wire  [sxmt_pkg::ENTRY_W-1:0] entry,
  input  wire                         key_bit,
  input  wire                         want_opp,
  input  wire                         dead_in,
  output sxmt_pkg::step_res_t          res
);
  import sxmt_pkg::*;

  logic              pref;
  logic [NODE_W-1:0] l_pref;
  logic [NODE_W-1:0] l_alt;

  always_comb begin
    pref   = key_bit ^ want_opp;
    l_pref = link_get(entry, pref);
    l_alt  = link_get(entry, ~pref);
    res    = '0;
    if (dead_in) begin
      res.dead = 1'b1;
    end else if (l_pref != '0) begin
      res.next_node = l_pref;
      res.bit_v     = want_opp;
    end else if (l_alt != '0) begin
      res.next_node = l_alt;
      res.bit_v     = ~want_opp;
    end else begin
      res.dead = 1'b1;
    end
  end

endmodule

`default_nettype wire

[tb/subarray_xor_max_min_trie_test.sv]
// ----------------------------------------------------------------------------
// subarray_xor_max_min_trie_test
// Drives value streams into the subarray XOR trie and compares every result
// with an independent trie predictor or, for typed table rows, with the values
// in the table. A short table of hand-picked items (extremes, set restarts and
// repeated prefixes) comes first. Random sets follow, closed by one long set
// that runs the node pool dry. Both the sender and the receiver pause at random between transfers.
// ----------------------------------------------------------------------------
module subarray_xor_max_min_trie_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int VB          = sxmt_pkg::VALUE_BITS;
  localparam int NODES       = sxmt_pkg::NODE_COUNT;
  localparam int MAX_GAP     = 18;
  localparam int DRAIN       = 80;
  localparam int SHORT_ITEMS = 150;
  localparam int LONG_CAP    = 3000;
  localparam int LONG_EXTRA  = 64;
  localparam int CYCLE_LIMIT = 2_000_000;

  typedef logic [VB-1:0] word_t;

  typedef struct packed {
    word_t max_x;
    word_t min_x;
    logic  full;
  } best_t;

  typedef struct packed {
    word_t value;
    logic  first;
    logic  typed;
    word_t max_x;
    word_t min_x;
    logic  full;
  } row_t;

  localparam int ROWS = 21;

  row_t plan [ROWS] = '{
    '{32'hFFFF_FFFF, 1'b0, 1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0},
    '{32'hFFFF_FFFF, 1'b0, 1'b1, 32'hFFFF_FFFF, 32'h0000_0000, 1'b0},
    '{32'h0000_0000, 1'b1, 1'b1, 32'h0000_0000, 32'h0000_0000, 1'b0},
    '{32'h0000_0000, 1'b0, 1'b1, 32'h0000_0000, 32'h0000_0000, 1'b0},
    '{32'h0000_0001, 1'b1, 1'b1, 32'h0000_0001, 32'h0000_0001, 1'b0},
    '{32'h8000_0000, 1'b0, 1'b1, 32'h8000_0001, 32'h0000_0001, 1'b0},
    '{32'h1234_5678, 1'b1, 1'b0, '0, '0, 1'b0},
    '{32'h1234_5678, 1'b0, 1'b0, '0, '0, 1'b0},
    '{32'hA5A5_A5A5, 1'b0, 1'b0, '0, '0, 1'b0},
    '{32'h5A5A_5A5A, 1'b0, 1'b0, '0, '0, 1'b0},
    '{32'h7FFF_FFFF, 1'b0, 1'b0, '0, '0, 1'b0},
    '{32'h8000_0000, 1'b0, 1'b0, '0, '0, 1'b0},
    '{32'h0000_0001, 1'b0, 1'b0, '0, '0, 1'b0},
    '{32'h0000_0002, 1'b0, 1'b0, '0, '0, 1'b0},
    '{32'h0000_0004, 1'b0, 1'b0, '0, '0, 1'b0},
    '{32'h4000_0000, 1'b0, 1'b0, '0, '0, 1'b0},
    '{32'hFFFF_0000, 1'b0, 1'b0, '0, '0, 1'b0},
    '{32'h0000_FFFF, 1'b0, 1'b0, '0, '0, 1'b0},
    '{32'hDEAD_BEEF, 1'b1, 1'b0, '0, '0, 1'b0},
    '{32'hDEAD_BEEF, 1'b0, 1'b0, '0, '0, 1'b0},
    '{32'h0000_0000, 1'b0, 1'b0, '0, '0, 1'b0}
  };

  logic  clk;
  logic  rst_n;
  logic  in_valid;
  logic  in_stall;
  word_t in_value;
  logic  in_first_of_set;
  logic  out_valid;
  logic  out_stall;
  word_t out_max_xor;
  word_t out_min_xor;
  logic  out_pool_full;

  subarray_xor_max_min_trie i_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_value        (in_value),
    .in_first_of_set (in_first_of_set),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_max_xor     (out_max_xor),
    .out_min_xor     (out_min_xor),
    .out_pool_full   (out_pool_full)
  );

  // Predictor state: node links, running prefix and best values of the set.
  int    kids [NODES][2];
  int    used;
  word_t prefix;
  word_t top;
  word_t bottom;
  logic  spilled;

  best_t best_q [$];
  best_t due;
  int    errors;
  int    items_sent;
  int    results_seen;
  int    sets_started;
  int    spill_results;
  int    cycles;
  bit    calm_in;
  bit    calm_out;

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("%0t: timeout, %0d results still pending", $time, best_q.size());
      $display("Simulation FAILED");
      $finish;
    end
  end

  task automatic clear_trie();
    kids[0][0] = 0;
    kids[0][1] = 0;
    used       = 1;
    prefix     = '0;
    top        = '0;
    bottom     = '1;
    spilled    = 1'b0;
  endtask

  function automatic word_t trie_walk(word_t key, bit far);
    int    node;
    int    nxt;
    int    i;
    logic  b;
    logic  pick;
    word_t acc;
    node = 0;
    acc  = '0;
    for (i = VB - 1; i >= 0; i--) begin
      b    = key[i];
      pick = far ? ~b : b;
      nxt  = kids[node][pick];
      acc  = acc << 1;
      if (nxt != 0) begin
        if (pick != b) acc[0] = 1'b1;
      end else begin
        nxt = kids[node][~pick];
        if (nxt == 0) begin
          acc = acc << i;
          return acc;
        end
        if (~pick != b) acc[0] = 1'b1;
      end
      node = nxt % NODES;
    end
    return acc;
  endfunction

  task automatic trie_insert(word_t key);
    int node;
    int i;
    node = 0;
    i    = VB - 1;
    while (i >= 0 && kids[node][key[i]] != 0) begin
      node = kids[node][key[i]] % NODES;
      i--;
    end
    if (used + i + 1 > NODES) begin
      spilled = 1'b1;
    end else begin
      for (; i >= 0; i--) begin
        kids[used][0]     = 0;
        kids[used][1]     = 0;
        kids[node][key[i]] = used;
        node              = used;
        used++;
      end
    end
  endtask

  task automatic xor_trie_step(word_t v, logic first, output best_t r);
    word_t hi;
    word_t lo;
    word_t a;
    word_t b;
    if (first) clear_trie();
    prefix = prefix ^ v;
    hi     = prefix;
    lo     = prefix;
    if (kids[0][0] != 0 || kids[0][1] != 0) begin
      a = trie_walk(prefix, 1'b1);
      b = trie_walk(prefix, 1'b0);
      if (a > hi) hi = a;
      if (b < lo) lo = b;
    end
    if (hi > top) top = hi;
    if (lo < bottom) bottom = lo;
    trie_insert(prefix);
    r.max_x = top;
    r.min_x = bottom;
    r.full  = spilled;
  endtask

  task automatic send_item(word_t v, logic first, logic typed, best_t typed_best);
    best_t pred;
    int    gap;
    if ($urandom_range(0, 49) == 0) calm_in = ~calm_in;
    gap = calm_in ? 0 : $urandom_range(0, MAX_GAP);
    if (gap != 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_value        = v;
    in_first_of_set = first;
    in_valid        = 1'b1;
    do @(posedge clk); while (in_stall);
    xor_trie_step(v, first, pred);
    best_q.push_back(typed ? typed_best : pred);
    items_sent++;
    if (first) sets_started++;
    @(negedge clk);
  endtask

  function automatic word_t pick_value(word_t last);
    word_t v;
    case ($urandom_range(0, 9))
      0, 1:    v = word_t'($urandom_range(0, 15));
      2:       v = word_t'(1) << $urandom_range(0, VB - 1);
      3: begin
        case ($urandom_range(0, 3))
          0:       v = '0;
          1:       v = '1;
          2:       v = 32'h8000_0000;
          default: v = 32'h7FFF_FFFF;
        endcase
      end
      4:       v = last;
      default: v = $urandom();
    endcase
    return v;
  endfunction

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      results_seen++;
      if (out_pool_full) spill_results++;
      if (best_q.size() == 0) begin
        errors++;
        $display("%0t: result with nothing pending: max %h min %h full %b",
                 $time, out_max_xor, out_min_xor, out_pool_full);
      end else begin
        due = best_q.pop_front();
        if (out_max_xor !== due.max_x) begin
          errors++;
          $display("%0t: max_xor expected %h actual %h", $time, due.max_x, out_max_xor);
        end
        if (out_min_xor !== due.min_x) begin
          errors++;
          $display("%0t: min_xor expected %h actual %h", $time, due.min_x, out_min_xor);
        end
        if (out_pool_full !== due.full) begin
          errors++;
          $display("%0t: pool_full expected %b actual %b", $time, due.full, out_pool_full);
        end
      end
    end
  end

  initial begin
    int w;
    out_stall = 1'b0;
    @(posedge rst_n);
    forever begin
      if ($urandom_range(0, 49) == 0) calm_out = ~calm_out;
      w = calm_out ? 0 : $urandom_range(0, MAX_GAP);
      if (w != 0) begin
        out_stall = 1'b1;
        repeat (w) @(negedge clk);
      end
      out_stall = 1'b0;
      do @(posedge clk); while (!out_valid);
      @(negedge clk);
    end
  end

  initial begin
    best_t none;
    best_t typed_best;
    word_t last;
    int    len;
    int    k;
    int    n;
    int    extra;
    none            = '0;
    in_valid        = 1'b0;
    in_value        = '0;
    in_first_of_set = 1'b0;
    rst_n           = 1'b0;
    errors          = 0;
    items_sent      = 0;
    results_seen    = 0;
    sets_started    = 0;
    spill_results   = 0;
    cycles          = 0;
    calm_in         = 1'b0;
    calm_out        = 1'b0;
    clear_trie();
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    for (k = 0; k < ROWS; k++) begin
      typed_best.max_x = plan[k].max_x;
      typed_best.min_x = plan[k].min_x;
      typed_best.full  = plan[k].full;
      send_item(plan[k].value, plan[k].first, plan[k].typed, typed_best);
    end

    last = '0;
    n    = 0;
    while (n < SHORT_ITEMS) begin
      len = $urandom_range(1, 40);
      for (k = 0; k < len; k++) begin
        last = pick_value(last);
        send_item(last, (k == 0) && ($urandom_range(0, 9) != 0), 1'b0, none);
        n++;
      end
    end

    // One long set of wide values fills the node pool and runs past it.
    n     = 0;
    extra = 0;
    send_item($urandom(), 1'b1, 1'b0, none);
    while (extra < LONG_EXTRA && n < LONG_CAP) begin
      send_item($urandom(), 1'b0, 1'b0, none);
      n++;
      if (spilled) extra++;
    end
    in_valid        = 1'b0;
    in_first_of_set = 1'b0;

    while (best_q.size() != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);

    $display("Sent %0d items in %0d restarted sets, checked %0d transfers.",
             items_sent, sets_started, results_seen);
    $display("The node pool ran out; %0d results carried the full flag.",
             spill_results);
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("%0d mismatches found.", errors);
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
